// ===== rtl/smq_pkg.sv =====
// Shared types and constants for the segment marquee scroller.
package smq_pkg;

  localparam int MSG_LEN_W = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int SEG_W     = 8;

  localparam logic [SEG_W-1:0] DP_MASK = 8'h80;

  typedef enum logic [1:0] {
    MODE_LOAD,
    MODE_RESTART,
    MODE_ADVANCE,
    MODE_RENDER
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MSG_LEN,
    CFG_SCROLL_REVERSE,
    CFG_DP_ENABLE,
    CFG_COUNT_PASSES
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_READ
  } state_t;

endpackage

// ===== rtl/smq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
module smq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/segment_marquee_scroller.sv =====
// Segment marquee scroller: message RAMs, scroll position and render sequencer.
//
// Load, restart and advance commands leave busy low. A render holds busy
// high while it runs in two phases, where VW is the width of the scroll
// position (7 at the default depth of 64): a one-bit-per-cycle remainder
// step over the VW position bits that folds the position into the wrapped
// length, then one RAM read per digit, as both message RAMs have a single
// read port. The DIGITS bytes then come out on consecutive cycles, each
// marked by strobe for one cycle; the receiver cannot stall them, and the
// next command may be started on the cycle of the last byte.
module segment_marquee_scroller
  import smq_pkg::*;
#(
  parameter int MSG_DEPTH = 64,
  parameter int DIGITS    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode,
  input  logic [5:0]           entry_index,
  input  logic [7:0]           seg_value,
  input  logic                 dp_flag,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 strobe,
  output logic [2:0]           digit_index,
  output logic [7:0]           segments,
  output logic                 last,
  output logic [7:0]           pass_total
);

  localparam int AW      = $clog2(MSG_DEPTH);
  localparam int MAX_LEN = (MSG_DEPTH < 127) ? MSG_DEPTH : 127;
  localparam int LW      = $clog2(MAX_LEN + 1);
  localparam int VW      = $clog2(MAX_LEN + 3);
  localparam int BW      = $clog2(VW);
  localparam int DW      = $clog2(DIGITS);

  // configuration
  logic [MSG_LEN_W-1:0] msg_len;
  logic                 scroll_reverse;
  logic                 dp_enable;
  logic                 count_passes;

  // scroll state
  logic [VW-1:0] position;
  logic [7:0]    pass_count;

  // render sequencer
  state_t        state, state_next;
  logic [VW-1:0] rem;
  logic [BW-1:0] bcnt;
  logic [VW-1:0] idx;
  logic [DW-1:0] dcnt;

  // read stage
  logic          rd_valid;
  logic [DW-1:0] rd_digit;
  logic          rd_inrange;
  logic          rd_dotok;

  logic [SEG_W-1:0] seg_q;
  logic             dot_q;

  logic            accept;
  logic            load_we;
  logic            mod_step;
  logic            issue;
  logic [LW-1:0]   eff_len;
  logic [VW-1:0]   virt;
  logic [VW:0]     shifted;
  logic [VW-1:0]   rem_next;
  logic [VW-1:0]   idx_inc;
  logic [VW-1:0]   rev;
  logic [AW-1:0]   seg_addr;
  logic [AW-1:0]   dot_addr;
  logic [AW-1:0]   load_addr;
  logic            load_inrange;
  logic [SEG_W-1:0] seg_out;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE) || rd_valid;

  always_comb begin
    if (32'(msg_len) > MSG_DEPTH) begin
      eff_len = LW'(MSG_DEPTH);
    end else begin
      eff_len = LW'(msg_len);
    end
  end

  assign virt     = VW'(eff_len) + VW'(2);
  assign shifted  = {rem, position[bcnt]};
  assign rem_next = (shifted >= {1'b0, virt}) ? VW'(shifted - {1'b0, virt}) : VW'(shifted);
  assign idx_inc  = ((idx + VW'(1)) == virt) ? '0 : idx + VW'(1);
  assign rev      = VW'(eff_len) - VW'(1) - idx;

  assign load_addr    = AW'(entry_index);
  assign load_inrange = 32'(entry_index) < MSG_DEPTH;
  assign seg_addr     = scroll_reverse ? AW'(rev) : AW'(idx);
  assign dot_addr     = scroll_reverse ? AW'(rev - VW'(1)) : AW'(idx);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (mode_t'(mode) == MODE_RENDER)) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (bcnt == '0) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (dcnt == DW'(DIGITS - 1)) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // sequencer controls
  always_comb begin
    load_we  = 1'b0;
    mod_step = 1'b0;
    issue    = 1'b0;
    unique case (state)
      S_IDLE: load_we  = accept && (mode_t'(mode) == MODE_LOAD) && load_inrange;
      S_MOD:  mod_step = 1'b1;
      S_READ: issue    = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_len        <= '0;
      scroll_reverse <= 1'b0;
      dp_enable      <= 1'b0;
      count_passes   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MSG_LEN:        msg_len        <= cfg_data;
        CFG_SCROLL_REVERSE: scroll_reverse <= cfg_data[0];
        CFG_DP_ENABLE:      dp_enable      <= cfg_data[0];
        CFG_COUNT_PASSES:   count_passes   <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      pass_count <= '0;
    end else if (accept) begin
      case (mode_t'(mode))
        MODE_RESTART: position <= '0;
        MODE_ADVANCE: begin
          if (!scroll_reverse) begin
            if (({1'b0, position} + (VW+1)'(1)) >= {1'b0, virt}) begin
              position <= '0;
            end else begin
              position <= position + VW'(1);
            end
          end else if (position == '0) begin
            position <= virt - VW'(1);
          end else begin
            position <= position - VW'(1);
          end
          if (count_passes) begin
            pass_count <= pass_count + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_valid <= 1'b0;
      strobe   <= 1'b0;
      last     <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      strobe   <= rd_valid;
      last     <= rd_valid && (rd_digit == DW'(DIGITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem  <= '0;
      bcnt <= BW'(VW - 1);
    end else if (mod_step) begin
      rem  <= rem_next;
      bcnt <= bcnt - BW'(1);
      if (bcnt == '0) begin
        idx  <= rem_next;
        dcnt <= '0;
      end
    end else if (issue) begin
      idx  <= idx_inc;
      dcnt <= dcnt + DW'(1);
    end
    rd_digit   <= dcnt;
    rd_inrange <= idx < VW'(eff_len);
    rd_dotok   <= dp_enable && (!scroll_reverse || (rev != '0));
  end

  always_comb begin
    seg_out = '0;
    if (rd_inrange) begin
      seg_out = seg_q | ((rd_dotok && dot_q) ? DP_MASK : '0);
    end
  end

  always_ff @(posedge clk) begin
    digit_index <= 3'(rd_digit);
    segments    <= seg_out;
  end

  assign pass_total = pass_count;

  smq_ram #(
    .WIDTH(SEG_W),
    .DEPTH(MSG_DEPTH)
  ) u_seg_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(load_addr),
    .wdata(seg_value),
    .raddr(seg_addr),
    .rdata(seg_q)
  );

  smq_ram #(
    .WIDTH(1),
    .DEPTH(MSG_DEPTH)
  ) u_dot_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(load_addr),
    .wdata(dp_flag),
    .raddr(dot_addr),
    .rdata(dot_q)
  );

endmodule

// ===== rtl/smq_chk.sv =====
// Port-level assertions for the segment marquee scroller, bound to the top level.
module smq_chk
  import smq_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       strobe,
  input logic [2:0] digit_index,
  input logic       last,
  input logic [7:0] pass_total
);

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("word strobed without a render in flight");

  a_render_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a render burst");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("word strobed right after the last digit");

  a_digit_order: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> digit_index == 3'($past(digit_index) + 3'd1))
    else $error("digit index out of order");

  a_count_steady: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> $stable(pass_total))
    else $error("pass count moved during a render");

endmodule

bind segment_marquee_scroller smq_chk u_smq_chk (.*);
